// File: src/vector_exchange_frame_checker_defines.svh
// assertion macros for the vector exchange frame checker
`ifndef VECTOR_EXCHANGE_FRAME_CHECKER_DEFINES_SVH
`define VECTOR_EXCHANGE_FRAME_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
`define VEFC_ASSERT_HOLD(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vefc assertion failed");
`define VEFC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vefc assertion failed");
`define VEFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vefc assertion failed");
`else
`define VEFC_ASSERT_HOLD(label, prop)
`define VEFC_ASSERT_IMPL(label, ante, cons)
`define VEFC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: src/vefc_pkg.sv
`default_nettype none
package vefc_pkg;

    localparam longint unsigned VEFC_MAX_FRAME_BYTES = 64'd16777216;
    localparam int unsigned HDR_LEN      = 80;
    localparam int unsigned HDR_CRC_SPAN = 72;
    localparam int unsigned MIN_FRAME    = 84;
    localparam logic [31:0] CRC_POLY     = 32'h82F63B78;
    localparam int unsigned POS_W        = 25;

    // status codes of a verdict
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HDR_BAD  = 3'd1;
    localparam logic [2:0] ST_VERSION  = 3'd2;
    localparam logic [2:0] ST_BATCH    = 3'd3;
    localparam logic [2:0] ST_CHECKSUM = 3'd4;
    localparam logic [2:0] ST_IDENTITY = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;
    localparam logic [2:0] ST_LIMITS   = 3'd7;

    // register indexes
    localparam logic [1:0] REG_MAX_FRAME = 2'd0;
    localparam logic [1:0] REG_MAX_BATCH = 2'd1;
    localparam logic [1:0] REG_MAJOR     = 2'd2;
    localparam logic [1:0] REG_MINOR     = 2'd3;

    localparam logic [63:0] MAGIC = 64'h3143455658444843; // "CHDXVEC1", first byte low

    typedef struct packed {
        logic        magic_ok;
        logic [15:0] major;
        logic [15:0] minor;
        logic [31:0] hlen;
        logic [63:0] flen;
        logic [63:0] id0;
        logic [63:0] id1;
        logic [63:0] id2;
        logic [63:0] id3;
        logic [63:0] seq;
        logic [31:0] flags;
        logic [31:0] batch;
        logic [31:0] hcrc;
        logic [31:0] resv;
        logic [31:0] hcrc_acc;
        logic [31:0] fcrc_acc;
        logic [31:0] last4;
    } vefc_fields_t;

    typedef struct packed {
        logic hdr_en;
        logic hcrc_en;
        logic fcrc_en;
        logic trail_en;
        logic clear;
    } vefc_cap_ctl_t;

    typedef struct packed {
        logic [24:0] max_frame;
        logic [24:0] max_batch;
        logic [15:0] major;
        logic [15:0] minor;
    } vefc_cfg_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] a;
        a = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
        end
        return a;
    endfunction

    function automatic vefc_fields_t fields_init();
        vefc_fields_t f;
        f = '0;
        f.magic_ok = 1'b1;
        f.hcrc_acc = 32'hFFFFFFFF;
        f.fcrc_acc = 32'hFFFFFFFF;
        return f;
    endfunction

endpackage
`default_nettype wire

// File: src/vefc_regs.sv
`default_nettype none
module vefc_regs
    import vefc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output vefc_cfg_t        cfg
);
    vefc_cfg_t cfg_reg;
    logic      wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame <= 25'd16777216;
            cfg_reg.max_batch <= 25'd16777132;
            cfg_reg.major     <= 16'd1;
            cfg_reg.minor     <= 16'd0;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_MAX_FRAME: cfg_reg.max_frame <= pwdata[24:0];
                REG_MAX_BATCH: cfg_reg.max_batch <= pwdata[24:0];
                REG_MAJOR:     cfg_reg.major     <= pwdata[15:0];
                REG_MINOR:     cfg_reg.minor     <= pwdata[15:0];
                default:       cfg_reg.minor     <= cfg_reg.minor;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_FRAME: prdata = {7'd0, cfg_reg.max_frame};
            REG_MAX_BATCH: prdata = {7'd0, cfg_reg.max_batch};
            REG_MAJOR:     prdata = {16'd0, cfg_reg.major};
            REG_MINOR:     prdata = {16'd0, cfg_reg.minor};
            default:       prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

// File: src/vefc_capture.sv
`default_nettype none
module vefc_capture
    import vefc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  vefc_cap_ctl_t      ctl,
    input  wire logic [6:0]    pos,
    input  wire logic [7:0]    dbyte,
    output vefc_fields_t       fields,
    output vefc_fields_t       fields_nxt
);
    vefc_fields_t fields_reg;
    vefc_fields_t fields_next;
    logic [6:0]   id_off;

    assign fields     = fields_reg;
    assign fields_nxt = fields_next;
    assign id_off     = pos - 7'd24;

    always_comb
    begin
        fields_next = fields_reg;
        if (ctl.hdr_en)
        begin
            if (pos < 7'd8)
            begin
                if (dbyte != MAGIC[8*pos[2:0] +: 8])
                begin
                    fields_next.magic_ok = 1'b0;
                end
            end
            else if (pos < 7'd10)
                fields_next.major[8*pos[0] +: 8] = dbyte;
            else if (pos < 7'd12)
                fields_next.minor[8*pos[0] +: 8] = dbyte;
            else if (pos < 7'd16)
                fields_next.hlen[8*pos[1:0] +: 8] = dbyte;
            else if (pos < 7'd24)
                fields_next.flen[8*pos[2:0] +: 8] = dbyte;
            else if (pos < 7'd56)
            begin
                case (id_off[4:3])
                    2'd0:    fields_next.id0 = {fields_reg.id0[55:0], dbyte};
                    2'd1:    fields_next.id1 = {fields_reg.id1[55:0], dbyte};
                    2'd2:    fields_next.id2 = {fields_reg.id2[55:0], dbyte};
                    default: fields_next.id3 = {fields_reg.id3[55:0], dbyte};
                endcase
            end
            else if (pos < 7'd64)
                fields_next.seq[8*pos[2:0] +: 8] = dbyte;
            else if (pos < 7'd68)
                fields_next.flags[8*pos[1:0] +: 8] = dbyte;
            else if (pos < 7'd72)
                fields_next.batch[8*pos[1:0] +: 8] = dbyte;
            else if (pos < 7'd76)
                fields_next.hcrc[8*pos[1:0] +: 8] = dbyte;
            else
                fields_next.resv[8*pos[1:0] +: 8] = dbyte;
        end
        if (ctl.hcrc_en)
            fields_next.hcrc_acc = crc_byte(fields_reg.hcrc_acc, dbyte);
        if (ctl.fcrc_en)
            fields_next.fcrc_acc = crc_byte(fields_reg.fcrc_acc, dbyte);
        if (ctl.trail_en)
            fields_next.last4 = {dbyte, fields_reg.last4[31:8]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fields_reg <= fields_init();
        else if (ctl.clear)
            fields_reg <= fields_init();
        else
            fields_reg <= fields_next;
    end
endmodule
`default_nettype wire

// File: src/vector_exchange_frame_checker.sv
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------------------
//  input    | in        | in_valid / in_stall    | data_byte
//  output   | out       | out_valid / out_stall  | kind payload_byte status terminal
//           |           |                        | sequence_res batch_len query_* tablet_*
//  config   | in        | apb psel/penable       | paddr pwdata prdata pready
//
//  one byte per cycle sustained while the output is not stalled: a byte is held in the input
//  register until it can move on, and is then resolved into the result register; the frame
//  checksum is a running crc-32c update; bytes that yield no result leave nothing
//  reset clears position, crc accumulators, captured fields, sticky failure, both valids
//  an output stall holds the result; the input keeps taking bytes while its register is
//  empty, and stalls once a held byte cannot move on
`default_nettype none
`include "vector_exchange_frame_checker_defines.svh"
module vector_exchange_frame_checker
    import vefc_pkg::*;
#(
    parameter longint unsigned MAX_FRAME_BYTES = VEFC_MAX_FRAME_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [7:0]       payload_byte,
    output logic [2:0]       status,
    output logic             terminal,
    output logic [63:0]      sequence_res,
    output logic [23:0]      batch_len,
    output logic [63:0]      query_high,
    output logic [63:0]      query_low,
    output logic [63:0]      tablet_high,
    output logic [63:0]      tablet_low,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic        terminal;
        logic [63:0] seq;
        logic [23:0] batch;
        logic [63:0] qh;
        logic [63:0] ql;
        logic [63:0] th;
        logic [63:0] tl;
    } vefc_result_t;

    vefc_cfg_t     cfg;
    vefc_cap_ctl_t cap_ctl;
    vefc_fields_t  cur;
    vefc_fields_t  nxt;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    // frame control
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             failed_reg, failed_next;
    logic [2:0]       held_reg, held_next;

    // result register
    logic         out_valid_reg;
    vefc_result_t out_reg, out_next;
    logic         emit;

    logic        proc;
    logic        limits_bad;
    logic [63:0] pos64;
    logic [2:0]  st_hdr;
    logic [2:0]  st_frm;
    logic        ver_bad_cur;
    logic        ver_bad_nxt;

    vefc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vefc_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cap_ctl),
        .pos        (pos_reg[6:0]),
        .dbyte      (s1_byte_reg),
        .fields     (cur),
        .fields_nxt (nxt)
    );

    // a held byte moves on when the result slot is free or being taken
    assign proc     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !proc;

    assign limits_bad = (cfg.max_frame < 25'(MIN_FRAME))
                     || ({39'd0, cfg.max_frame} > 64'(MAX_FRAME_BYTES))
                     || (cfg.max_batch == 25'd0);
    assign pos64 = {39'd0, pos_reg};

    assign ver_bad_cur = (cur.major != cfg.major) || (cur.minor != cfg.minor);
    assign ver_bad_nxt = (nxt.major != cfg.major) || (nxt.minor != cfg.minor);

    // header checks on the fields including the last header byte
    always_comb
    begin
        if (!nxt.magic_ok
            || (nxt.hcrc != ~nxt.hcrc_acc)
            || (nxt.hlen != 32'(HDR_LEN))
            || (nxt.flen < 64'(MIN_FRAME))
            || (nxt.flen > {39'd0, cfg.max_frame})
            || (nxt.flags[31:1] != 31'd0)
            || ({32'd0, nxt.batch} != nxt.flen - 64'(MIN_FRAME))
            || (nxt.resv != 32'd0))
            st_hdr = ST_HDR_BAD;
        else if (ver_bad_nxt)
            st_hdr = ST_VERSION;
        else if ({32'd0, nxt.batch} > {39'd0, cfg.max_batch})
            st_hdr = ST_BATCH;
        else
            st_hdr = ST_OK;
    end

    // frame end checks; the trailer word includes the last byte
    always_comb
    begin
        if (ver_bad_cur)
            st_frm = ST_VERSION;
        else if (cur.flen > {39'd0, cfg.max_frame})
            st_frm = ST_HDR_BAD;
        else if (nxt.last4 != ~cur.fcrc_acc)
            st_frm = ST_CHECKSUM;
        else if (((cur.id0 | cur.id1) == 64'd0) || ((cur.id2 | cur.id3) == 64'd0)
                 || (cur.seq == 64'd0))
            st_frm = ST_IDENTITY;
        else if ((cur.batch == 32'd0) && !cur.flags[0])
            st_frm = ST_EMPTY;
        else
            st_frm = ST_OK;
    end

    function automatic vefc_result_t verdict(input vefc_fields_t f, input logic [2:0] st);
        vefc_result_t r;
        r.kind         = 1'b1;
        r.payload_byte = 8'd0;
        r.status       = st;
        r.terminal     = f.flags[0];
        r.seq          = f.seq;
        r.batch        = f.batch[23:0];
        r.qh           = f.id0;
        r.ql           = f.id1;
        r.th           = f.id2;
        r.tl           = f.id3;
        return r;
    endfunction

    // per byte decision: sticky failure, bad limits, header, payload, trailer
    always_comb
    begin
        cap_ctl     = '0;
        pos_next    = pos_reg;
        failed_next = failed_reg;
        held_next   = held_reg;
        emit        = 1'b0;
        out_next    = verdict(cur, held_reg);
        if (proc)
        begin
            if (failed_reg)
            begin
                emit = 1'b1;
            end
            else if (limits_bad)
            begin
                emit     = 1'b1;
                out_next = verdict(cur, ST_LIMITS);
            end
            else if (pos_reg < POS_W'(HDR_LEN))
            begin
                cap_ctl.hdr_en  = 1'b1;
                cap_ctl.hcrc_en = pos_reg < POS_W'(HDR_CRC_SPAN);
                cap_ctl.fcrc_en = 1'b1;
                pos_next        = pos_reg + 1'b1;
                if ((pos_reg == POS_W'(HDR_LEN - 1)) && (st_hdr != ST_OK))
                begin
                    emit        = 1'b1;
                    failed_next = 1'b1;
                    held_next   = st_hdr;
                    out_next    = verdict(nxt, st_hdr);
                end
            end
            else if (pos64 + 64'd4 < cur.flen)
            begin
                // payload cut-through
                cap_ctl.fcrc_en = 1'b1;
                pos_next        = pos_reg + 1'b1;
                emit            = 1'b1;
                out_next        = '0;
                out_next.payload_byte = s1_byte_reg;
            end
            else
            begin
                cap_ctl.trail_en = 1'b1;
                pos_next         = pos_reg + 1'b1;
                if (!(pos64 + 64'd1 < cur.flen))
                begin
                    emit = 1'b1;
                    if (st_frm != ST_OK)
                    begin
                        failed_next = 1'b1;
                        held_next   = st_frm;
                        out_next    = verdict(cur, st_frm);
                    end
                    else
                    begin
                        out_next      = verdict(cur, ST_OK);
                        cap_ctl.clear = 1'b1;
                        pos_next      = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            failed_reg    <= 1'b0;
            held_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                s1_valid_reg <= 1'b1;
            else if (proc)
                s1_valid_reg <= 1'b0;
            pos_reg    <= pos_next;
            failed_reg <= failed_next;
            held_reg   <= held_next;
            if (proc)
                out_valid_reg <= emit;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_byte_reg <= data_byte;
        if (proc && emit)
            out_reg <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign payload_byte = out_reg.payload_byte;
    assign status       = out_reg.status;
    assign terminal     = out_reg.terminal;
    assign sequence_res = out_reg.seq;
    assign batch_len    = out_reg.batch;
    assign query_high   = out_reg.qh;
    assign query_low    = out_reg.ql;
    assign tablet_high  = out_reg.th;
    assign tablet_low   = out_reg.tl;

    `VEFC_ASSERT_HOLD(a_stall_needs_held_byte, !in_stall || s1_valid_reg)
    `VEFC_ASSERT_IMPL(a_payload_clean, out_valid && !kind, status == ST_OK && sequence_res == 64'd0)
    `VEFC_ASSERT_NEXT(a_failure_sticky, failed_reg, failed_reg)
    `VEFC_ASSERT_IMPL(a_failed_always_emits, proc && failed_reg, emit)
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none
module tb;
    import vefc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // result kinds carried on the kind port
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;
    localparam int   CYCLE_LIMIT  = 40000;
    localparam int   DRAIN_CYCLES = 8;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload;
        logic [2:0]  status;
        logic        terminal;
        logic [63:0] seq;
        logic [23:0] batch;
        logic [63:0] qhi;
        logic [63:0] qlo;
        logic [63:0] thi;
        logic [63:0] tlo;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic        terminal;
    logic [63:0] sequence_res;
    logic [23:0] batch_len;
    logic [63:0] query_high;
    logic [63:0] query_low;
    logic [63:0] tablet_high;
    logic [63:0] tablet_low;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    vector_exchange_frame_checker dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // checker state copy: configuration
    longint unsigned cfg_max_frame = 16777216;
    longint unsigned cfg_max_batch = 16777132;
    logic [15:0]     cfg_major = 16'd1;
    logic [15:0]     cfg_minor = 16'd0;

    // checker state copy: frame progress and captured header
    longint unsigned pos;
    logic [31:0]     hdr_crc;
    logic [31:0]     frm_crc;
    logic [31:0]     trailer;
    logic [63:0]     flen;
    logic [63:0]     seqno;
    logic [63:0]     resv;
    logic [31:0]     major_f;
    logic [31:0]     minor_f;
    logic [31:0]     hlen_f;
    logic [31:0]     flags_f;
    logic [31:0]     batch_f;
    logic [31:0]     hcrc_f;
    logic [63:0]     ident [4];
    logic            magic_ok;
    logic            sticky_fail = 1'b0;
    logic [2:0]      held_st = ST_OK;

    frame_result_t   pending_results [$];
    logic [7:0]      frame_q [$];

    int send_idle = 0;
    int recv_idle = 0;
    int hold_off = 0;
    int mismatches = 0;
    int cycles = 0;

    function automatic logic [31:0] crc32c_update(logic [31:0] acc, logic [7:0] b);
        logic [31:0] a;
        a = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            a = a[0] ? ((a >> 1) ^ 32'h82F63B78) : (a >> 1);
        end
        return a;
    endfunction

    task automatic clear_frame_state();
        pos = 0;
        hdr_crc = '1;
        frm_crc = '1;
        trailer = '0;
        flen = '0;
        seqno = '0;
        resv = '0;
        major_f = '0;
        minor_f = '0;
        hlen_f = '0;
        flags_f = '0;
        batch_f = '0;
        hcrc_f = '0;
        for (int i = 0; i < 4; i++)
        begin
            ident[i] = '0;
        end
        magic_ok = 1'b1;
    endtask

    task automatic push_verdict(logic [2:0] st);
        frame_result_t r;
        r = '0;
        r.kind = KIND_VERDICT;
        r.status = st;
        r.terminal = flags_f[0];
        r.seq = seqno;
        r.batch = batch_f[23:0];
        r.qhi = ident[0];
        r.qlo = ident[1];
        r.thi = ident[2];
        r.tlo = ident[3];
        pending_results = {pending_results, r};
    endtask

    function automatic logic version_bad();
        return major_f != {16'd0, cfg_major} || minor_f != {16'd0, cfg_minor};
    endfunction

    function automatic logic [2:0] header_status();
        if (!magic_ok || hcrc_f != ~hdr_crc || hlen_f != 80 || flen < 84
            || flen > cfg_max_frame || flags_f[31:1] != 0
            || {32'd0, batch_f} != flen - 64'd84 || resv != 0)
            return ST_HDR_BAD;
        if (version_bad())
            return ST_VERSION;
        if ({32'd0, batch_f} > cfg_max_batch)
            return ST_BATCH;
        return ST_OK;
    endfunction

    function automatic logic [2:0] frame_status();
        if (version_bad())
            return ST_VERSION;
        if (flen > cfg_max_frame)
            return ST_HDR_BAD;
        if (trailer != ~frm_crc)
            return ST_CHECKSUM;
        if ((ident[0] | ident[1]) == 0 || (ident[2] | ident[3]) == 0 || seqno == 0)
            return ST_IDENTITY;
        if (batch_f == 0 && !flags_f[0])
            return ST_EMPTY;
        return ST_OK;
    endfunction

    task automatic capture_header_byte(int p, logic [7:0] b);
        logic [63:0] magic_word;
        magic_word = 64'h3143455658444843;
        if (p < 8)
        begin
            if (b != magic_word[8*p +: 8])
                magic_ok = 1'b0;
        end
        else if (p < 10)
            major_f[8*(p-8) +: 8] = b;
        else if (p < 12)
            minor_f[8*(p-10) +: 8] = b;
        else if (p < 16)
            hlen_f[8*(p-12) +: 8] = b;
        else if (p < 24)
            flen[8*(p-16) +: 8] = b;
        else if (p < 56)
            ident[(p-24) >> 3] = {ident[(p-24) >> 3][55:0], b};
        else if (p < 64)
            seqno[8*(p-56) +: 8] = b;
        else if (p < 68)
            flags_f[8*(p-64) +: 8] = b;
        else if (p < 72)
            batch_f[8*(p-68) +: 8] = b;
        else if (p < 76)
            hcrc_f[8*(p-72) +: 8] = b;
        else
            resv[8*(p-76) +: 8] = b;
    endtask

    // works out what one accepted byte causes
    task automatic predict_byte(logic [7:0] b);
        frame_result_t r;
        logic [2:0] st;
        if (sticky_fail)
        begin
            push_verdict(held_st);
            return;
        end
        if (cfg_max_frame < 84 || cfg_max_frame > 16777216 || cfg_max_batch == 0)
        begin
            push_verdict(ST_LIMITS);
            return;
        end
        if (pos < 80)
        begin
            capture_header_byte(int'(pos), b);
            if (pos < 72)
                hdr_crc = crc32c_update(hdr_crc, b);
            frm_crc = crc32c_update(frm_crc, b);
            pos++;
            if (pos == 80)
            begin
                st = header_status();
                if (st != ST_OK)
                begin
                    sticky_fail = 1'b1;
                    held_st = st;
                    push_verdict(st);
                end
            end
            return;
        end
        if (pos + 4 < flen)
        begin
            frm_crc = crc32c_update(frm_crc, b);
            pos++;
            r = '0;
            r.kind = KIND_PAYLOAD;
            r.payload = b;
            pending_results = {pending_results, r};
            return;
        end
        trailer = {b, trailer[31:8]};
        pos++;
        if (pos < flen)
            return;
        st = frame_status();
        if (st != ST_OK)
        begin
            sticky_fail = 1'b1;
            held_st = st;
            push_verdict(st);
            return;
        end
        push_verdict(ST_OK);
        clear_frame_state();
    endtask

    // one input transfer, with random idle cycles in front of it
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        predict_byte(b);
    endtask

    task automatic send_queue();
        foreach (frame_q[i])
        begin
            send_byte(frame_q[i]);
        end
        in_valid <= 1'b0;
    endtask

    // waits until nothing is pending, then lets the block drain
    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAX_FRAME: cfg_max_frame = value[24:0];
            REG_MAX_BATCH: cfg_max_batch = value[24:0];
            REG_MAJOR:     cfg_major = value[15:0];
            REG_MINOR:     cfg_minor = value[15:0];
            default:       cfg_minor = cfg_minor;
        endcase
    endtask

    task automatic push_le(logic [63:0] v, int n);
        for (int i = 0; i < n; i++)
        begin
            frame_q = {frame_q, v[8*i +: 8]};
        end
    endtask

    // well-formed frame with random identity and payload
    task automatic build_frame(logic term, int unsigned blen);
        logic [31:0] crc;
        frame_q.delete();
        push_le(64'h3143455658444843, 8);
        push_le({48'd0, cfg_major}, 2);
        push_le({48'd0, cfg_minor}, 2);
        push_le(64'd80, 4);
        push_le(64'd84 + blen, 8);
        for (int i = 0; i < 32; i++)
        begin
            frame_q = {frame_q, 8'($urandom()) | ((i % 16 == 0) ? 8'h01 : 8'h00)};
        end
        push_le({$urandom(), $urandom()} | 64'd1, 8);
        push_le({63'd0, term}, 4);
        push_le({32'd0, blen}, 4);
        crc = '1;
        for (int i = 0; i < 72; i++)
        begin
            crc = crc32c_update(crc, frame_q[i]);
        end
        push_le({32'd0, ~crc}, 4);
        push_le(64'd0, 4);
        for (int i = 0; i < int'(blen); i++)
        begin
            frame_q = {frame_q, 8'($urandom())};
        end
        crc = '1;
        foreach (frame_q[i])
        begin
            crc = crc32c_update(crc, frame_q[i]);
        end
        push_le({32'd0, ~crc}, 4);
    endtask

    // tightest valid limits and extreme versions, then the widest limits
    task automatic test_config_extremes();
        write_reg(REG_MAX_FRAME, 32'd84);
        write_reg(REG_MAX_BATCH, 32'd1);
        write_reg(REG_MAJOR, 32'hFFFF);
        write_reg(REG_MINOR, 32'hFFFF);
        build_frame(1'b1, 0);
        send_queue();
        write_reg(REG_MAX_FRAME, 32'd16777216);
        write_reg(REG_MAX_BATCH, 32'd16777216);
        write_reg(REG_MAJOR, 32'd0);
        write_reg(REG_MINOR, 32'd0);
    endtask

    // bytes offered while limits are invalid are dropped with a verdict
    task automatic test_invalid_limits();
        write_reg(REG_MAX_FRAME, 32'd83);
        frame_q = '{8'h43, 8'h00, 8'hFF};
        send_queue();
        write_reg(REG_MAX_FRAME, 32'h1FFFFFF);
        send_queue();
        write_reg(REG_MAX_FRAME, 32'd16777216);
        write_reg(REG_MAX_BATCH, 32'd0);
        send_queue();
        write_reg(REG_MAX_BATCH, 32'd16777132);
    endtask

    task automatic test_random_frames(int s_idle, int r_idle, int n_items);
        int sent;
        int unsigned blen;
        logic term;
        send_idle = s_idle;
        recv_idle = r_idle;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(3) == 0)
            begin
                write_reg(REG_MAJOR, $urandom_range(65535));
                write_reg(REG_MINOR, $urandom_range(65535));
                write_reg(REG_MAX_FRAME, $urandom_range(16777216, 124));
                write_reg(REG_MAX_BATCH, $urandom_range(16777216, 40));
            end
            term = 1'($urandom());
            blen = $urandom_range(4, term ? 0 : 1);
            build_frame(term, blen);
            send_queue();
            sent += frame_q.size();
        end
    endtask

    // receiver holds off long enough that the block fills and stalls its input
    task automatic test_output_holdoff();
        send_idle = 0;
        recv_idle = 0;
        build_frame(1'b0, 2);
        hold_off = 300;
        send_queue();
    endtask

    // a bad trailer fails the frame and every later byte repeats that verdict
    task automatic test_sticky_failure();
        build_frame(1'b1, 0);
        frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ 8'h5A;
        send_queue();
        frame_q = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h43};
        send_queue();
    endtask

    // receiver stall: the long hold-off when armed, random idling otherwise
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off = hold_off - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    // output side: compare every result transfer with the prediction
    always @(posedge clk)
    begin
        frame_result_t got;
        frame_result_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind, payload_byte, status, terminal, sequence_res, batch_len,
                    query_high, query_low, tablet_high, tablet_low};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
    end

    initial
    begin
        clear_frame_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_random_frames(32, 56, 80);
        test_config_extremes();
        test_invalid_limits();
        test_random_frames(56, 32, 80);
        test_output_holdoff();
        test_sticky_failure();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
